FILE: rtl/egc_pkg.sv
// ----------------------------------------------------------------------------
// egc_pkg
// Shared types, codes and constants for the Euler graph classifier.
// ----------------------------------------------------------------------------
package egc_pkg;

	// Default vertex capacity and fixed field widths
	localparam int MAX_VERTICES_DEF = 64;
	localparam int VCOUNT_W         = 7;
	localparam int VERT_W           = 6;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

	// Item kinds
	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Graph type codes
	localparam logic [1:0] GT_NON   = 2'd0;
	localparam logic [1:0] GT_SEMI  = 2'd1;
	localparam logic [1:0] GT_EULER = 2'd2;

	// Odd-vertex count after three strip steps: this value means "more than two"
	localparam logic [1:0] ODD_MANY = 2'd3;

	// Input beat
	typedef struct packed {
		logic              kind;
		logic [VERT_W-1:0] vertex_a;
		logic [VERT_W-1:0] vertex_b;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic [1:0] graph_type;
		logic       bad_edge_seen;
	} out_item_t;

	// Controller to datapath commands
	typedef struct packed {
		logic edge_load;    // record edge in bit vectors, read row a
		logic edge_bad;     // drop edge, set bad flag
		logic wr_a;         // write row a, read row b
		logic wr_b;         // write row b
		logic class_init;   // seed walk, load odd vector
		logic odd_step;     // strip lowest odd bit, count it
		logic walk_pick;    // pick a pending vertex, read its row
		logic walk_merge;   // OR fetched row into reached set
		logic result_load;  // load result register, clear graph state
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic edge_bad;
		logic self_loop;
		logic found;
		logic pending_any;
	} status_t;

endpackage

FILE: rtl/euler_graph_classifier.sv
// ----------------------------------------------------------------------------
// euler_graph_classifier
// Classifies an undirected graph, loaded one edge per beat, as Eulerian,
// semi-Eulerian or non-Eulerian.
// ----------------------------------------------------------------------------
// Steps: an edge beat is a read-modify-write of two rows (one for a
// self-loop) of the single-port-write adjacency RAM; an edge with an
// out-of-range endpoint is dropped without a write. A finish beat counts
// odd vertices, walks from a seed vertex and then waits for the result
// slot; the walk is skipped when no vertex below the count has an edge. The
// walk reaches at most MAX_VERTICES vertices: each reached vertex costs one
// row read from the adjacency RAM and one merge, and one more pick finds
// the walk done. The result sits in an output register, so edge beats keep
// flowing while it waits. Each adjacency row has a valid bit that reset and
// every finish clear at once, so there is no clearing pass.
// ----------------------------------------------------------------------------
module euler_graph_classifier #(
	parameter int MAX_VERTICES = egc_pkg::MAX_VERTICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [egc_pkg::VCOUNT_W-1:0] cfg_wdata,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  egc_pkg::in_item_t            item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output egc_pkg::out_item_t           result
);

	egc_pkg::cmd_t    cmd;
	egc_pkg::status_t status;

	// Controller
	egc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_kind    (item.kind),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd),
		.item_ready   (item_ready),
		.result_valid (result_valid)
	);

	// Datapath
	egc_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

FILE: rtl/egc_ram.sv
// ----------------------------------------------------------------------------
// egc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module egc_ram #(
	parameter int WIDTH = egc_pkg::MAX_VERTICES_DEF,
	parameter int DEPTH = egc_pkg::MAX_VERTICES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/egc_dp.sv
// ----------------------------------------------------------------------------
// egc_dp
// Datapath: vertex count register, per-vertex bit vectors, adjacency RAM with
// per-row valid bits, reachability walk and odd-degree counting.
// ----------------------------------------------------------------------------
module egc_dp #(
	parameter int MAX_VERTICES = egc_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [egc_pkg::VCOUNT_W-1:0]  cfg_wdata,
	input  egc_pkg::in_item_t             item,
	input  egc_pkg::cmd_t                 cmd,
	output egc_pkg::status_t              status,
	output egc_pkg::out_item_t            result
);

	localparam int VIW = $clog2(MAX_VERTICES);

	logic [egc_pkg::VCOUNT_W-1:0] vcount_q;
	logic [MAX_VERTICES-1:0]      vmask;
	logic [VIW-1:0]               a_idx, b_idx, a_q, b_q;
	logic [MAX_VERTICES-1:0]      row_valid_q, parity_q, has_edge_q;
	logic [MAX_VERTICES-1:0]      reached_q, visited_q, odd_q;
	logic [1:0]                   odd_cnt_q;
	logic                         found_q, bad_q, rvalid_q;
	egc_pkg::out_item_t           result_q;

	logic [MAX_VERTICES-1:0]      sel, iso, row, pending;
	logic [VIW-1:0]               pick_idx;
	logic [VIW-1:0]               raddr, waddr;
	logic [MAX_VERTICES-1:0]      wdata, rdata;
	logic                         we;
	logic                         conn_bad;
	logic [1:0]                   gtype;

	// Vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= egc_pkg::VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// Vertices below the effective count
	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vmask[i] = int'(vcount_q) > i;
		end
	end

	assign a_idx = VIW'(item.vertex_a);
	assign b_idx = VIW'(item.vertex_b);

	// Endpoint range check
	assign status.edge_bad = (int'(item.vertex_a) >= int'(vcount_q))
		|| (int'(item.vertex_b) >= int'(vcount_q))
		|| (int'(item.vertex_a) >= MAX_VERTICES)
		|| (int'(item.vertex_b) >= MAX_VERTICES);
	assign status.self_loop   = (a_q == b_q);
	assign status.found       = found_q;
	assign pending            = reached_q & ~visited_q;
	assign status.pending_any = |pending;

	// Lowest set bit: seed vertex at init, next pending vertex during walk
	assign sel = cmd.class_init ? (has_edge_q & vmask) : pending;
	assign iso = sel & ((~sel) + MAX_VERTICES'(1));

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			pick_idx = pick_idx | (iso[i] ? VIW'(i) : VIW'(0));
		end
	end

	// Fetched row; a never-written row reads as empty
	assign row = rvalid_q ? rdata : '0;

	// Adjacency RAM port selection
	always_comb begin
		raddr = a_idx;
		if (cmd.wr_a) begin
			raddr = b_q;
		end else if (cmd.walk_pick) begin
			raddr = pick_idx;
		end
		we    = cmd.wr_a | cmd.wr_b;
		waddr = cmd.wr_b ? b_q : a_q;
		wdata = row | (cmd.wr_b ? (MAX_VERTICES'(1) << a_q) : (MAX_VERTICES'(1) << b_q));
	end

	egc_ram #(
		.WIDTH (MAX_VERTICES),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Row valid bits and per-vertex records
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			parity_q    <= '0;
			has_edge_q  <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (cmd.edge_load) begin
				parity_q   <= parity_q ^ (MAX_VERTICES'(1) << a_idx)
					^ (MAX_VERTICES'(1) << b_idx);
				has_edge_q <= has_edge_q | (MAX_VERTICES'(1) << a_idx)
					| (MAX_VERTICES'(1) << b_idx);
			end
			if (cmd.edge_bad) begin
				bad_q <= 1'b1;
			end
			if (cmd.wr_a) begin
				row_valid_q[a_q] <= 1'b1;
			end
			if (cmd.wr_b) begin
				row_valid_q[b_q] <= 1'b1;
			end
			if (cmd.result_load) begin
				row_valid_q <= '0;
				parity_q    <= '0;
				has_edge_q  <= '0;
				bad_q       <= 1'b0;
			end
		end
	end

	// Edge endpoints, read-valid tag
	always_ff @(posedge clk) begin
		rvalid_q <= row_valid_q[raddr];
		if (cmd.edge_load) begin
			a_q <= a_idx;
			b_q <= b_idx;
		end
	end

	// Walk and odd-degree counting
	always_ff @(posedge clk) begin
		if (cmd.class_init) begin
			found_q   <= |sel;
			reached_q <= iso;
			visited_q <= '0;
			odd_q     <= parity_q & vmask;
			odd_cnt_q <= 2'd0;
		end
		if (cmd.odd_step) begin
			odd_q <= odd_q & (odd_q - MAX_VERTICES'(1));
			if (|odd_q) begin
				odd_cnt_q <= odd_cnt_q + 2'd1;
			end
		end
		if (cmd.walk_pick) begin
			visited_q <= visited_q | iso;
		end
		if (cmd.walk_merge) begin
			reached_q <= reached_q | row;
		end
	end

	// Classification
	assign conn_bad = found_q && (|(has_edge_q & ~reached_q & vmask));

	always_comb begin
		if (conn_bad || (odd_cnt_q == egc_pkg::ODD_MANY)) begin
			gtype = egc_pkg::GT_NON;
		end else if (odd_cnt_q == 2'd0) begin
			gtype = egc_pkg::GT_EULER;
		end else begin
			gtype = egc_pkg::GT_SEMI;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			result_q.graph_type    <= gtype;
			result_q.bad_edge_seen <= bad_q;
		end
	end

	assign result = result_q;

endmodule

FILE: rtl/egc_ctrl.sv
// ----------------------------------------------------------------------------
// egc_ctrl
// Controller: sequences edge read-modify-writes, the classification walk and
// the result handoff.
// ----------------------------------------------------------------------------
module egc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_kind,
	input  logic             result_ready,
	input  egc_pkg::status_t status,
	output egc_pkg::cmd_t    cmd,
	output logic             item_ready,
	output logic             result_valid
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EDGE_A = 4'd1;
	localparam logic [3:0] S_EDGE_B = 4'd2;
	localparam logic [3:0] S_ODD0   = 4'd3;
	localparam logic [3:0] S_ODD1   = 4'd4;
	localparam logic [3:0] S_ODD2   = 4'd5;
	localparam logic [3:0] S_PICK   = 4'd6;
	localparam logic [3:0] S_MERGE  = 4'd7;
	localparam logic [3:0] S_RESULT = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign slot_free    = !out_valid_q || result_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (item_kind == egc_pkg::KIND_FINISH) begin
						cmd.class_init = 1'b1;
						state_d        = S_ODD0;
					end else if (status.edge_bad) begin
						cmd.edge_bad = 1'b1;
					end else begin
						cmd.edge_load = 1'b1;
						state_d       = S_EDGE_A;
					end
				end
			end
			S_EDGE_A: begin
				cmd.wr_a = 1'b1;
				state_d  = status.self_loop ? S_IDLE : S_EDGE_B;
			end
			S_EDGE_B: begin
				cmd.wr_b = 1'b1;
				state_d  = S_IDLE;
			end
			S_ODD0: begin
				cmd.odd_step = 1'b1;
				state_d      = S_ODD1;
			end
			S_ODD1: begin
				cmd.odd_step = 1'b1;
				state_d      = S_ODD2;
			end
			S_ODD2: begin
				cmd.odd_step = 1'b1;
				state_d      = status.found ? S_PICK : S_RESULT;
			end
			S_PICK: begin
				if (status.pending_any) begin
					cmd.walk_pick = 1'b1;
					state_d       = S_MERGE;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_MERGE: begin
				cmd.walk_merge = 1'b1;
				state_d        = S_PICK;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.result_load = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// A result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> slot_free)
		else $error("result loaded over a pending beat");

	// An accepted finish beat starts odd counting next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_kind == egc_pkg::KIND_FINISH)
		|=> state_q == S_ODD0)
		else $error("finish beat did not start classification");

	// Output valid rises only after the result state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESULT)
		else $error("result valid without classification");

	// A row merge always follows a pick
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> $past(cmd.walk_pick))
		else $error("merge without a fetched row");
`endif

endmodule

FILE: tb/sv/euler_graph_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_graph_classifier_tb
// Self-checking bench for the Euler graph classifier. Directed graphs cover
// the corner cases: empty graph, self-loops, dropped links, vertex count
// clamping and a count lowered after loading. Random closed and open walks
// with noise follow under three idle/stall profiles. A bit-level graph model
// predicts each classification, and a monitor compares every result beat.
// ----------------------------------------------------------------------------
module euler_graph_classifier_tb;

	localparam int NV           = egc_pkg::MAX_VERTICES_DEF;
	localparam int VERT_W       = egc_pkg::VERT_W;
	localparam int VCOUNT_W     = egc_pkg::VCOUNT_W;
	localparam int SETTLE_CYC   = 16;
	localparam int TAIL_CYC     = 2 * NV + 40; // longest walk plus margin
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_BEATS = 1850;
	localparam int MAX_REPORTS  = 100;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [VCOUNT_W-1:0] cfg_wdata;
	logic                item_valid;
	logic                item_ready;
	egc_pkg::in_item_t   item;
	logic                result_valid;
	logic                result_ready = 1'b0;
	egc_pkg::out_item_t  result;

	// Graph model
	logic [NV-1:0]       adj_model [NV];
	logic [NV-1:0]       odd_model;
	logic [NV-1:0]       has_model;
	logic                bad_model;
	logic [VCOUNT_W-1:0] vcount_model;

	egc_pkg::out_item_t  pending_results [$];
	egc_pkg::out_item_t  want_result;
	int                  fail_count   = 0;
	int                  beats_sent   = 0;
	int                  quiet_cycles = 0;
	int                  tx_idle_pct;
	int                  rx_stall_pct;

	euler_graph_classifier u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Graph model
	// ------------------------------------------------------------------
	function automatic int unsigned eff_vertices();
		return (vcount_model > NV) ? NV : vcount_model;
	endfunction

	function automatic void model_clear();
		int i;
		for (i = 0; i < NV; i++)
			adj_model[i] = '0;
		odd_model = '0;
		has_model = '0;
		bad_model = 1'b0;
	endfunction

	// Walk from the highest in-range vertex with links, then check parity
	function automatic logic [1:0] predict_type();
		int unsigned   n;
		int            i;
		int            start;
		int            odd;
		logic [NV-1:0] mask;
		logic [NV-1:0] reached;
		logic [NV-1:0] frontier;
		logic [NV-1:0] nxt;
		n     = eff_vertices();
		mask  = (n >= NV) ? '1 : (({{(NV-1){1'b0}}, 1'b1} << n) - 1'b1);
		start = -1;
		for (i = 0; i < int'(n); i++)
			if (has_model[i])
				start = i;
		if (start >= 0) begin
			reached  = '0;
			reached[start] = 1'b1;
			frontier = reached;
			while (frontier != '0) begin
				nxt = '0;
				for (i = 0; i < NV; i++)
					if (frontier[i])
						nxt |= adj_model[i];
				frontier = nxt & ~reached;
				reached |= frontier;
			end
			if ((has_model & ~reached & mask) != '0)
				return egc_pkg::GT_NON;
		end
		odd = $countones(odd_model & mask);
		if (odd > 2)
			return egc_pkg::GT_NON;
		return (odd == 0) ? egc_pkg::GT_EULER : egc_pkg::GT_SEMI;
	endfunction

	// Update the model for one accepted beat
	function automatic void model_accept(input egc_pkg::in_item_t beat);
		int unsigned        n;
		egc_pkg::out_item_t res;
		n = eff_vertices();
		if (beat.kind == egc_pkg::KIND_FINISH) begin
			res.graph_type    = predict_type();
			res.bad_edge_seen = bad_model;
			pending_results.insert(pending_results.size(), res);
			model_clear();
		end else if (beat.vertex_a >= n || beat.vertex_b >= n) begin
			bad_model = 1'b1;
		end else begin
			adj_model[beat.vertex_a][beat.vertex_b] = 1'b1;
			adj_model[beat.vertex_b][beat.vertex_a] = 1'b1;
			odd_model[beat.vertex_a] = ~odd_model[beat.vertex_a];
			odd_model[beat.vertex_b] = ~odd_model[beat.vertex_b];
			has_model[beat.vertex_a] = 1'b1;
			has_model[beat.vertex_b] = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Beat helpers
	// ------------------------------------------------------------------
	function automatic egc_pkg::in_item_t link_beat(input logic [VERT_W-1:0] a,
		input logic [VERT_W-1:0] b);
		egc_pkg::in_item_t beat;
		beat.kind     = egc_pkg::KIND_EDGE;
		beat.vertex_a = a;
		beat.vertex_b = b;
		return beat;
	endfunction

	function automatic egc_pkg::in_item_t finish_beat();
		egc_pkg::in_item_t beat;
		beat.kind     = egc_pkg::KIND_FINISH;
		beat.vertex_a = VERT_W'($urandom_range(NV - 1));
		beat.vertex_b = VERT_W'($urandom_range(NV - 1));
		return beat;
	endfunction

	// Mostly in range, sometimes past the current vertex count
	function automatic logic [VERT_W-1:0] pick_vertex();
		int unsigned n;
		n = eff_vertices();
		if (n == 0 || n >= NV)
			return VERT_W'($urandom_range(NV - 1));
		if ($urandom_range(11) == 0)
			return VERT_W'($urandom_range(NV - 1, n));
		return VERT_W'($urandom_range(n - 1));
	endfunction

	function automatic logic [VCOUNT_W-1:0] random_count();
		int r;
		r = $urandom_range(19);
		if (r < 12)
			return VCOUNT_W'($urandom_range(12, 1));
		if (r < 15)
			return VCOUNT_W'(NV);
		if (r == 15)
			return VCOUNT_W'(1);
		if (r == 16)
			return '0;
		if (r == 17)
			return VCOUNT_W'($urandom_range(127, 65));
		return VCOUNT_W'($urandom_range(63, 13));
	endfunction

	// Send one beat; valid stays up after acceptance for the next beat
	task automatic send_beat(input egc_pkg::in_item_t beat);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= beat;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		model_accept(beat);
		beats_sent++;
	endtask

	// Hold off the sender until every classification has come back
	task automatic wait_results_done();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_vertex_count(input logic [VCOUNT_W-1:0] count);
		wait_results_done();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_wdata <= count;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we       <= 1'b0;
		vcount_model = count;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall, check against the oldest prediction
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("MISMATCH @%0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", int'(result), 0);
			end else begin
				want_result = pending_results.pop_front();
				if (result.graph_type !== want_result.graph_type)
					report_mismatch("graph_type", result.graph_type,
						want_result.graph_type);
				if (result.bad_edge_seen !== want_result.bad_edge_seen)
					report_mismatch("bad_edge_seen", result.bad_edge_seen,
						want_result.bad_edge_seen);
			end
		end
	end

	// Watchdog on beats moving in either direction
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TIMEOUT @%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("euler_graph_classifier test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Basic shapes at the reset vertex count
	task automatic test_small_graphs();
		// empty graph
		send_beat(finish_beat());
		// single link between the extreme vertices
		send_beat(link_beat(0, 63));
		send_beat(finish_beat());
		// triangle
		send_beat(link_beat(0, 1));
		send_beat(link_beat(1, 2));
		send_beat(link_beat(2, 0));
		send_beat(finish_beat());
		// self-loop keeps parity, plus one link
		send_beat(link_beat(5, 5));
		send_beat(link_beat(5, 6));
		send_beat(finish_beat());
		// two components
		send_beat(link_beat(0, 1));
		send_beat(link_beat(2, 3));
		send_beat(finish_beat());
		// four odd vertices
		send_beat(link_beat(0, 1));
		send_beat(link_beat(0, 2));
		send_beat(link_beat(0, 3));
		send_beat(finish_beat());
	endtask

	// Out-of-range endpoints, zero count and a clamped count
	task automatic test_dropped_links();
		set_vertex_count(5);
		send_beat(link_beat(4, 5));
		send_beat(link_beat(63, 0));
		send_beat(link_beat(1, 2));
		send_beat(finish_beat());
		set_vertex_count(0);
		send_beat(link_beat(0, 0));
		send_beat(finish_beat());
		set_vertex_count(127);
		send_beat(link_beat(62, 63));
		send_beat(finish_beat());
	endtask

	// Links stay stored when the count drops; the walk passes above it
	task automatic test_count_lowered();
		set_vertex_count(VCOUNT_W'(NV));
		send_beat(link_beat(10, 50));
		send_beat(link_beat(50, 40));
		set_vertex_count(41);
		send_beat(finish_beat());
	endtask

	// One random graph followed by its finish beat
	task automatic random_graph();
		int                shape;
		int                len;
		int                k;
		logic [VERT_W-1:0] first;
		logic [VERT_W-1:0] cur;
		logic [VERT_W-1:0] nxt;
		if ($urandom_range(3) == 0)
			set_vertex_count(random_count());
		shape = $urandom_range(9);
		len   = ($urandom_range(15) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
		first = pick_vertex();
		cur   = first;
		case (shape)
			0, 1, 2, 3, 4, 5, 6: begin
				// closed walk for shapes 0..3, open walk otherwise
				for (k = 0; k < len; k++) begin
					nxt = pick_vertex();
					send_beat(link_beat(cur, nxt));
					cur = nxt;
				end
				if (shape <= 3)
					send_beat(link_beat(cur, first));
			end
			7: begin
				for (k = 0; k < len; k++)
					send_beat(link_beat(pick_vertex(), pick_vertex()));
			end
			8: begin
				// walk with stray links mixed in
				for (k = 0; k < len; k++) begin
					if ($urandom_range(3) == 0) begin
						send_beat(link_beat(VERT_W'($urandom_range(NV - 1)),
							VERT_W'($urandom_range(NV - 1))));
					end else begin
						nxt = pick_vertex();
						send_beat(link_beat(cur, nxt));
						cur = nxt;
					end
				end
			end
			default: begin
				for (k = 0; k < int'($urandom_range(2)); k++) begin
					nxt = pick_vertex();
					send_beat(link_beat(nxt, nxt));
				end
			end
		endcase
		if ($urandom_range(19) == 0)
			set_vertex_count(random_count());
		send_beat(finish_beat());
		if ($urandom_range(7) == 0)
			wait_results_done();
	endtask

	task automatic test_random_graphs(input int beats, input int tx_pct, input int rx_pct);
		int first_beat;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		first_beat   = beats_sent;
		while (beats_sent - first_beat < beats)
			random_graph();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		item_valid   = 1'b0;
		item         = '0;
		tx_idle_pct  = 16;
		rx_stall_pct = 60;
		vcount_model = egc_pkg::VCOUNT_RESET;
		model_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_graphs();
		test_dropped_links();
		test_count_lowered();
		test_random_graphs(RANDOM_BEATS / 3, 16, 60);
		test_random_graphs(RANDOM_BEATS / 3, 60, 16);
		test_random_graphs(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3), 0, 0);

		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never produced", pending_results.size(), 0);
		if (fail_count == 0)
			$display("euler_graph_classifier test passed");
		else
			$display("euler_graph_classifier test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/egc_pkg.sv
rtl/egc_ram.sv
rtl/egc_dp.sv
rtl/egc_ctrl.sv
rtl/euler_graph_classifier.sv
tb/sv/euler_graph_classifier_tb.sv
